// ===== hw/rtl/tlbl_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbl_pkg
// Shared types, sizes and request codes for the LRU translation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbl_pkg;

   // Table geometry and field widths.
   localparam int ENTRIES    = 64;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int PAGE_BITS  = 20;
   localparam int FRAME_BITS = 8;
   localparam int AGE_BITS   = 16;
   localparam int KIND_BITS  = 2;
   localparam int SLOT_BITS  = 6;

   // Fill count value that means every entry holds a translation.
   localparam logic [CNT_BITS-1:0] FILL_FULL = CNT_BITS'(ENTRIES);

   // Request kinds.
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd2;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [PAGE_BITS-1:0]  page;
      logic [FRAME_BITS-1:0] frame;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [FRAME_BITS-1:0] frame_out;
      logic                  replaced;
      logic [SLOT_BITS-1:0]  slot;
   } rsp_type;

   // One stored translation.
   typedef struct packed {
      logic [PAGE_BITS-1:0]  page;
      logic [FRAME_BITS-1:0] frame;
      logic [AGE_BITS-1:0]   age;
   } entry_type;

   // Port controls from the sequencer to the entry memory.
   typedef struct packed {
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
   } ram_ctl_type;

   // Entry index reported as a slot number, modulo the slot field range.
   function automatic logic [SLOT_BITS-1:0] to_slot(input logic [IDX_BITS-1:0] idx);
      logic [SLOT_BITS+IDX_BITS-1:0] wide;
      wide = {{SLOT_BITS{1'b0}}, idx};
      return wide[SLOT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tlbl_entry_ram.sv =====
// ----------------------------------------------------------------------------
// tlbl_entry_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_entry_ram (
   input  wire logic                  clock,
   input  wire tlbl_pkg::ram_ctl_type ctl,
   output tlbl_pkg::entry_type        rd_data
);
   import tlbl_pkg::*;

   entry_type entry_mem_ff [ENTRIES];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   // Read port; read data is registered and appears in the cycle after rd_en.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= entry_mem_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tlbl_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// tlbl_rsp_reg
// Output register that holds a finished result while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tlbl_pkg::rsp_type in_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tlbl_pkg::rsp_type      rsp_data
);
   import tlbl_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    load;

   // The register can take a new result when empty or when it drains now.
   assign in_ready = !valid_ff || !rsp_stall;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= in_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tlbl_seq.sv =====
// ----------------------------------------------------------------------------
// tlbl_seq
// Request sequencer: scans the entry memory, tracks the fill count and
// builds the result of each request.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tlbl_pkg::req_type     req_data,
   output tlbl_pkg::ram_ctl_type      ram_ctl,
   input  wire tlbl_pkg::entry_type   ram_rd_data,
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output tlbl_pkg::rsp_type          res_data
);
   import tlbl_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]          state_ff,    state_in;
   req_type             item_ff,     item_in;
   logic [CNT_BITS-1:0] fill_ff,     fill_in;
   logic [CNT_BITS-1:0] rd_idx_ff,   rd_idx_in;
   logic                pend_ff,     pend_in;
   logic [IDX_BITS-1:0] pend_idx_ff, pend_idx_in;
   logic [AGE_BITS-1:0] best_age_ff, best_age_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;
   rsp_type             res_ff,      res_in;

   // Next-state logic for the scan sequencer.
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      fill_in     = fill_ff;
      rd_idx_in   = rd_idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = rd_idx_ff[IDX_BITS-1:0];
      best_age_in = best_age_ff;
      best_idx_in = best_idx_ff;
      res_in      = res_ff;
      ram_ctl         = '0;
      ram_ctl.rd_addr = rd_idx_ff[IDX_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_START;
            end
         end
         ST_START: begin
            res_in      = '0;
            rd_idx_in   = '0;
            best_age_in = '0;
            best_idx_in = '0;
            unique case (item_ff.kind)
               KIND_LOOKUP, KIND_TICK: begin
                  state_in = (fill_ff == '0) ? ST_DONE : ST_SCAN;
               end
               KIND_INSERT: begin
                  if (fill_ff != FILL_FULL) begin
                     // A free entry remains: the next one in fill order.
                     ram_ctl.wr_en         = 1'b1;
                     ram_ctl.wr_addr       = fill_ff[IDX_BITS-1:0];
                     ram_ctl.wr_data.page  = item_ff.page;
                     ram_ctl.wr_data.frame = item_ff.frame;
                     ram_ctl.wr_data.age   = '0;
                     res_in.slot           = to_slot(fill_ff[IDX_BITS-1:0]);
                     fill_in               = fill_ff + 1'b1;
                     state_in              = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            // Issue the next read while entries remain.
            if (rd_idx_ff < fill_ff) begin
               ram_ctl.rd_en = 1'b1;
               rd_idx_in     = rd_idx_ff + 1'b1;
               pend_in       = 1'b1;
            end
            if (pend_ff) begin
               // Work on the entry read in the previous cycle.
               unique case (item_ff.kind)
                  KIND_LOOKUP: begin
                     if (ram_rd_data.page == item_ff.page) begin
                        ram_ctl.wr_en       = 1'b1;
                        ram_ctl.wr_addr     = pend_idx_ff;
                        ram_ctl.wr_data     = ram_rd_data;
                        ram_ctl.wr_data.age = '0;
                        res_in.hit          = 1'b1;
                        res_in.frame_out    = ram_rd_data.frame;
                        res_in.slot         = to_slot(pend_idx_ff);
                        state_in            = ST_DONE;
                     end
                  end
                  KIND_TICK: begin
                     ram_ctl.wr_en   = 1'b1;
                     ram_ctl.wr_addr = pend_idx_ff;
                     ram_ctl.wr_data = ram_rd_data;
                     if (!(&ram_rd_data.age)) begin
                        ram_ctl.wr_data.age = ram_rd_data.age + 1'b1;
                     end
                  end
                  KIND_INSERT: begin
                     if (ram_rd_data.age > best_age_ff) begin
                        best_age_in = ram_rd_data.age;
                        best_idx_in = pend_idx_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (rd_idx_ff == fill_ff) begin
               // Scan finished; a full-table insert replaces the oldest entry.
               state_in = ST_DONE;
               if (item_ff.kind == KIND_INSERT) begin
                  ram_ctl.wr_en         = 1'b1;
                  ram_ctl.wr_addr       = best_idx_ff;
                  ram_ctl.wr_data.page  = item_ff.page;
                  ram_ctl.wr_data.frame = item_ff.frame;
                  ram_ctl.wr_data.age   = '0;
                  res_in.replaced       = 1'b1;
                  res_in.slot           = to_slot(best_idx_ff);
               end
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      best_age_ff <= best_age_in;
      best_idx_ff <= best_idx_in;
      res_ff      <= res_in;
   end

   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= FILL_FULL)
      else $error("fill count exceeds table size");

   // The fill count only holds or grows by one.
   assert property (@(posedge clock) disable iff (reset)
      ##1 ((fill_ff == $past(fill_ff)) || (fill_ff == $past(fill_ff) + 1'b1)))
      else $error("fill count moved by more than one");

   // Reads only touch entries that have been written.
   assert property (@(posedge clock) disable iff (reset)
      ram_ctl.rd_en |-> (rd_idx_ff < fill_ff))
      else $error("read of an unwritten entry");

   // Writes go to a filled entry or to the next free one.
   assert property (@(posedge clock) disable iff (reset)
      ram_ctl.wr_en |-> ({1'b0, ram_ctl.wr_addr} <= fill_ff))
      else $error("write beyond the filled region");

endmodule

`default_nettype wire

// ===== hw/rtl/tlb_lru_translation_unit.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_translation_unit
// Fully associative translation buffer with age-based LRU replacement,
// held in a single-port-write, single-port-read entry memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload             Handshake
//  req      in         tlbl_pkg::req_type  req_valid / req_stall
//  rsp      out        tlbl_pkg::rsp_type  rsp_valid / rsp_stall
//
//  A lookup or tick scans the filled entries one entry per cycle through
//  the memory read port; an empty table is not scanned. A lookup that hits
//  an entry stops the scan there. An insert into a table with free entries
//  writes the next free entry without a scan; one into a full table scans
//  all entries for the oldest and replaces it.
//  Reset empties the table at once through the fill count; no clearing pass.
//  One request is worked on at a time; a finished result waits in the output
//  register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_lru_translation_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tlbl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tlbl_pkg::rsp_type      rsp_data
);
   import tlbl_pkg::*;

   ram_ctl_type ram_ctl;
   entry_type   ram_rd_data;
   logic        res_valid;
   logic        res_ready;
   rsp_type     res_data;

   // Entry memory.
   tlbl_entry_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_data (ram_rd_data)
   );

   // Scan sequencer.
   tlbl_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .ram_ctl     (ram_ctl),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data)
   );

   // Output register.
   tlbl_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
